[sv/rlpv_pkg.sv]
`timescale 1ns / 1ps

package rlpv_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned FRAME_W  = 17;
	localparam int unsigned STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CORRUPT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NEED_MORE = 2'd2;

	localparam logic [LEN_W-1:0]  DEFAULT_MAX_STRING = 16'h0100;
	localparam logic [DATA_W-1:0] VERSION_FLAG       = 8'h04;

	// Smallest complete frame: size prefix, header, count and trailer.
	localparam logic [FRAME_W-1:0] MIN_FRAME_BYTES = 17'd10;

	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  realm_total;
		logic [FRAME_W-1:0]  frame_bytes;
	} result_t;

endpackage

[sv/rlpv_intf.sv]
`timescale 1ns / 1ps

interface rlpv_in_if;
	logic                        valid;
	logic                        ready;
	logic [rlpv_pkg::DATA_W-1:0] data_byte;
	logic                        last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rlpv_out_if;
	logic                          valid;
	logic                          ready;
	logic [rlpv_pkg::STATUS_W-1:0] status;
	logic [rlpv_pkg::COUNT_W-1:0]  realm_total;
	logic [rlpv_pkg::FRAME_W-1:0]  frame_bytes;

	modport source (output valid, output status, output realm_total, output frame_bytes,
		input ready);
	modport sink (input valid, input status, input realm_total, input frame_bytes,
		output ready);
endinterface

interface rlpv_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [rlpv_pkg::LEN_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/realm_list_packet_validator_top.sv]
`timescale 1ns / 1ps

// A completing byte is held in the input register, its result in the output register.
// One byte per clock unless a result waits; the state register updates once per byte.
// A result that waits at the output stalls the parser, but one more byte is still taken.
// Reset (arst_n low, asynchronous) empties both stages, restarts at the size prefix
// and sets max_string_length to 256.

module realm_list_packet_validator_top (
	input  logic            clk,
	input  logic            arst_n,
	rlpv_in_if.sink         in_ch,
	rlpv_out_if.source      out_ch,
	rlpv_cfg_if.sink        cfg_ch
);

	logic                           valid_s1;
	logic [rlpv_pkg::DATA_W-1:0]    byte_s1;
	logic                           last_s1;
	logic                           step;
	logic [rlpv_pkg::LEN_W-1:0]     max_len_q;
	rlpv_pkg::result_t              res;
	logic                           out_valid_q;
	logic [rlpv_pkg::STATUS_W-1:0]  status_q;
	logic [rlpv_pkg::COUNT_W-1:0]   count_q;
	logic [rlpv_pkg::FRAME_W-1:0]   frame_q;

	assign step = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || step;
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= rlpv_pkg::DEFAULT_MAX_STRING;
		end else if (cfg_ch.valid) begin
			max_len_q <= cfg_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	rlpv_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.data_byte         (byte_s1),
		.last_byte         (last_s1),
		.max_string_length (max_len_q),
		.result            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res.valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			status_q <= res.status;
			count_q <= res.realm_total;
			frame_q <= res.frame_bytes;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.status = status_q;
	assign out_ch.realm_total = count_q;
	assign out_ch.frame_bytes = frame_q;

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid |=> out_ch.valid)
		else $error("parser result was not registered at the output");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.status == rlpv_pkg::ST_ACCEPTED
			|| out_ch.status == rlpv_pkg::ST_CORRUPT
			|| out_ch.status == rlpv_pkg::ST_NEED_MORE))
		else $error("result carries an undefined status code");

	a_accept_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == rlpv_pkg::ST_ACCEPTED
			|-> out_ch.frame_bytes >= rlpv_pkg::MIN_FRAME_BYTES)
		else $error("accepted frame is shorter than the minimum structure");

	a_no_step_while_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !step)
		else $error("parser advanced while the output slot was occupied");

endmodule

[sv/rlpv_parser.sv]
`timescale 1ns / 1ps

module rlpv_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [rlpv_pkg::DATA_W-1:0]    data_byte,
	input  logic                           last_byte,
	input  logic [rlpv_pkg::LEN_W-1:0]     max_string_length,
	output rlpv_pkg::result_t              result
);

	localparam logic [4:0] PH_SIZE_LO  = 5'd0;
	localparam logic [4:0] PH_SIZE_HI  = 5'd1;
	localparam logic [4:0] PH_HEADER   = 5'd2;
	localparam logic [4:0] PH_COUNT_LO = 5'd3;
	localparam logic [4:0] PH_COUNT_HI = 5'd4;
	localparam logic [4:0] PH_R_F0     = 5'd5;
	localparam logic [4:0] PH_R_F1     = 5'd6;
	localparam logic [4:0] PH_R_FLAGS  = 5'd7;
	localparam logic [4:0] PH_NAME     = 5'd8;
	localparam logic [4:0] PH_ADDR     = 5'd9;
	localparam logic [4:0] PH_POP      = 5'd10;
	localparam logic [4:0] PH_R_A      = 5'd11;
	localparam logic [4:0] PH_R_B      = 5'd12;
	localparam logic [4:0] PH_R_C      = 5'd13;
	localparam logic [4:0] PH_VERSION  = 5'd14;
	localparam logic [4:0] PH_TRAIL    = 5'd15;
	localparam logic [4:0] PH_DONE     = 5'd16;
	localparam logic [4:0] PH_SKIP     = 5'd17;

	typedef struct packed {
		logic [4:0]                    phase;
		logic [rlpv_pkg::LEN_W-1:0]    bytes_left;
		logic [rlpv_pkg::LEN_W-1:0]    declared_size;
		logic [rlpv_pkg::COUNT_W-1:0]  realms_left;
		logic [rlpv_pkg::COUNT_W-1:0]  announced;
		logic [rlpv_pkg::LEN_W-1:0]    string_length;
		logic [2:0]                    field_idx;
		logic                          version_present;
		logic                          structure_error;
	} parse_state_t;

	localparam parse_state_t CLEAR_STATE = '{
		phase: PH_SIZE_LO, bytes_left: '0, declared_size: '0, realms_left: '0,
		announced: '0, string_length: '0, field_idx: '0, version_present: 1'b0,
		structure_error: 1'b0};

	parse_state_t st_q;
	parse_state_t st_d;
	parse_state_t nx;
	logic [2:0]   idx_inc;
	logic         done_ok;

	assign idx_inc = st_q.field_idx + 3'd1;

	// Body byte handling: advances the field machine for one byte.
	always_comb begin
		nx = st_q;
		nx.bytes_left = st_q.bytes_left - 16'd1;
		unique case (st_q.phase) inside
			PH_HEADER: begin
				nx.field_idx = idx_inc;
				if (idx_inc == 3'd4) begin
					nx.field_idx = 3'd0;
					nx.phase = PH_COUNT_LO;
				end
			end
			PH_COUNT_LO: begin
				nx.announced = {8'd0, data_byte};
				nx.phase = PH_COUNT_HI;
			end
			PH_COUNT_HI: begin
				nx.announced = {data_byte, st_q.announced[7:0]};
				nx.realms_left = {data_byte, st_q.announced[7:0]};
				nx.field_idx = 3'd0;
				nx.phase = ({data_byte, st_q.announced[7:0]} != 16'd0) ? PH_R_F0 : PH_TRAIL;
			end
			PH_R_F0: nx.phase = PH_R_F1;
			PH_R_F1: nx.phase = PH_R_FLAGS;
			PH_R_FLAGS: begin
				nx.version_present = (data_byte & rlpv_pkg::VERSION_FLAG) != 8'd0;
				nx.string_length = '0;
				nx.phase = PH_NAME;
			end
			PH_NAME, PH_ADDR: begin
				if (data_byte == 8'd0) begin
					if (st_q.string_length > max_string_length) begin
						nx.structure_error = 1'b1;
						nx.phase = PH_SKIP;
					end else begin
						nx.string_length = '0;
						nx.phase = (st_q.phase == PH_NAME) ? PH_ADDR : PH_POP;
					end
				end else if (st_q.string_length != 16'hFFFF) begin
					nx.string_length = st_q.string_length + 16'd1;
				end
				if (st_q.phase == PH_ADDR) begin
					nx.field_idx = 3'd0;
				end
			end
			PH_POP: begin
				nx.field_idx = idx_inc;
				if (idx_inc == 3'd4) begin
					nx.field_idx = 3'd0;
					nx.phase = PH_R_A;
				end
			end
			PH_R_A: nx.phase = PH_R_B;
			PH_R_B: nx.phase = PH_R_C;
			PH_R_C, PH_VERSION: begin
				if (st_q.phase == PH_R_C && st_q.version_present) begin
					nx.field_idx = 3'd0;
					nx.phase = PH_VERSION;
				end else if (st_q.phase == PH_R_C || idx_inc == 3'd5) begin
					// End of one realm entry.
					nx.realms_left = st_q.realms_left - 16'd1;
					nx.field_idx = 3'd0;
					nx.phase = (st_q.realms_left != 16'd1) ? PH_R_F0 : PH_TRAIL;
				end else begin
					nx.field_idx = idx_inc;
				end
			end
			PH_TRAIL: begin
				nx.field_idx = idx_inc;
				if (idx_inc == 3'd2) begin
					nx.field_idx = 3'd0;
					nx.phase = PH_DONE;
				end
			end
			PH_DONE: begin
				nx.structure_error = 1'b1;
				nx.phase = PH_SKIP;
			end
			default: ;
		endcase
	end

	assign done_ok = !nx.structure_error && nx.phase == PH_DONE;

	always_comb begin
		st_d = st_q;
		result.valid = 1'b0;
		result.status = rlpv_pkg::ST_NEED_MORE;
		result.realm_total = '0;
		result.frame_bytes = '0;
		if (step) begin
			if (st_q.phase == PH_SIZE_LO) begin
				st_d = CLEAR_STATE;
				st_d.declared_size = {8'd0, data_byte};
				st_d.phase = PH_SIZE_HI;
				if (last_byte) begin
					st_d = CLEAR_STATE;
					result.valid = 1'b1;
					result.frame_bytes = 17'd1;
				end
			end else if (st_q.phase == PH_SIZE_HI) begin
				st_d.declared_size = {data_byte, st_q.declared_size[7:0]};
				st_d.bytes_left = {data_byte, st_q.declared_size[7:0]};
				st_d.field_idx = 3'd0;
				st_d.phase = PH_HEADER;
				if (data_byte == 8'd0 && st_q.declared_size[7:0] == 8'd0) begin
					// Empty body can never be a complete frame.
					st_d = CLEAR_STATE;
					result.valid = 1'b1;
					result.status = rlpv_pkg::ST_CORRUPT;
					result.frame_bytes = 17'd2;
				end else if (last_byte) begin
					st_d = CLEAR_STATE;
					result.valid = 1'b1;
					result.frame_bytes = 17'd2;
				end
			end else begin
				st_d = nx;
				if (nx.bytes_left == 16'd0) begin
					st_d = CLEAR_STATE;
					result.valid = 1'b1;
					result.status = done_ok ? rlpv_pkg::ST_ACCEPTED : rlpv_pkg::ST_CORRUPT;
					result.realm_total = done_ok ? nx.announced : 16'd0;
					result.frame_bytes = {1'b0, st_q.declared_size} + 17'd2;
				end else if (last_byte) begin
					st_d = CLEAR_STATE;
					result.valid = 1'b1;
					result.frame_bytes = {1'b0, st_q.declared_size} + 17'd2
						- {1'b0, nx.bytes_left};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CLEAR_STATE;
		end else begin
			st_q <= st_d;
		end
	end

endmodule

[test/realm_list_packet_validator_top_tb.sv]
`timescale 1ns / 1ps

module realm_list_packet_validator_top_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_BYTES    = 80;

	typedef enum logic [4:0] {
		P_SIZE_LO, P_SIZE_HI, P_HEADER, P_COUNT_LO, P_COUNT_HI, P_REALM_F0, P_REALM_F1,
		P_REALM_FLAGS, P_NAME, P_ADDR, P_POP, P_REALM_A, P_REALM_B, P_REALM_C, P_VERSION,
		P_TRAIL, P_DONE, P_SKIP
	} parse_phase_t;

	typedef enum int {
		FR_GOOD, FR_EXTRA, FR_SHORT, FR_CUT, FR_LONG_STR, FR_BADCOUNT, FR_NOISE
	} frame_kind_t;

	typedef struct packed {
		logic [rlpv_pkg::DATA_W-1:0] data;
		logic                        last;
	} stream_byte_t;

	typedef struct packed {
		logic [rlpv_pkg::STATUS_W-1:0] status;
		logic [rlpv_pkg::COUNT_W-1:0]  realm_total;
		logic [rlpv_pkg::FRAME_W-1:0]  frame_bytes;
	} verdict_t;

	logic clk;
	logic arst_n;

	rlpv_in_if  in_ch();
	rlpv_out_if out_ch();
	rlpv_cfg_if cfg_ch();

	realm_list_packet_validator_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	stream_byte_t pending_bytes[$];
	verdict_t     expected_verdicts[$];

	// Frame checker state as seen by the predictor.
	logic [rlpv_pkg::LEN_W-1:0]   max_len = rlpv_pkg::DEFAULT_MAX_STRING;
	parse_phase_t                 phase = P_SIZE_LO;
	logic [rlpv_pkg::LEN_W-1:0]   body_left = '0;
	logic [rlpv_pkg::LEN_W-1:0]   declared_size = '0;
	logic [rlpv_pkg::COUNT_W-1:0] realms_left = '0;
	logic [rlpv_pkg::COUNT_W-1:0] realms_announced = '0;
	logic [rlpv_pkg::LEN_W-1:0]   str_len = '0;
	logic [2:0]                   field_idx = '0;
	logic                         has_version = 1'b0;
	logic                         broken = 1'b0;

	int errors = 0;
	int bytes_taken = 0;
	int n_accepted = 0;
	int n_corrupt = 0;
	int n_need_more = 0;
	int cfg_writes = 0;
	int idle_cycles = 0;

	stream_byte_t cur_byte;
	int burst_left = 0;
	int gap_left = 0;

	logic [15:0] stall_pattern = 16'hFFFF;
	int pattern_age = 0;
	verdict_t seen;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic post_verdict(input logic [rlpv_pkg::STATUS_W-1:0] st,
		input logic [rlpv_pkg::COUNT_W-1:0] cnt, input logic [rlpv_pkg::FRAME_W-1:0] nbytes);
		expected_verdicts.push_back('{status: st, realm_total: cnt, frame_bytes: nbytes});
		phase = P_SIZE_LO;
		body_left = '0;
		declared_size = '0;
		realms_left = '0;
		realms_announced = '0;
		str_len = '0;
		field_idx = '0;
		has_version = 1'b0;
		broken = 1'b0;
	endtask

	task automatic close_frame();
		logic ok;
		ok = !broken && phase == P_DONE;
		post_verdict(ok ? rlpv_pkg::ST_ACCEPTED : rlpv_pkg::ST_CORRUPT,
			ok ? realms_announced : '0, {1'b0, declared_size} + 17'd2);
	endtask

	task automatic close_realm();
		realms_left = realms_left - 1'b1;
		field_idx = '0;
		phase = (realms_left != 0) ? P_REALM_F0 : P_TRAIL;
	endtask

	// Advances the frame checker by one stream byte and queues any verdict it yields.
	task automatic parse_byte(input logic [rlpv_pkg::DATA_W-1:0] b, input logic lst);
		if (phase == P_SIZE_LO) begin
			declared_size = {8'h00, b};
			phase = P_SIZE_HI;
			if (lst)
				post_verdict(rlpv_pkg::ST_NEED_MORE, '0, 17'd1);
		end else if (phase == P_SIZE_HI) begin
			declared_size[15:8] = b;
			body_left = declared_size;
			field_idx = '0;
			phase = P_HEADER;
			if (body_left == 0)
				close_frame();
			else if (lst)
				post_verdict(rlpv_pkg::ST_NEED_MORE, '0, 17'd2);
		end else begin
			body_left = body_left - 1'b1;
			case (phase) inside
				P_HEADER: begin
					field_idx = field_idx + 1'b1;
					if (field_idx == 3'd4) begin
						field_idx = '0;
						phase = P_COUNT_LO;
					end
				end
				P_COUNT_LO: begin
					realms_announced = {8'h00, b};
					phase = P_COUNT_HI;
				end
				P_COUNT_HI: begin
					realms_announced[15:8] = b;
					realms_left = realms_announced;
					field_idx = '0;
					phase = (realms_left != 0) ? P_REALM_F0 : P_TRAIL;
				end
				P_REALM_F0: phase = P_REALM_F1;
				P_REALM_F1: phase = P_REALM_FLAGS;
				P_REALM_FLAGS: begin
					has_version = (b & rlpv_pkg::VERSION_FLAG) != 0;
					str_len = '0;
					phase = P_NAME;
				end
				P_NAME, P_ADDR: begin
					if (b == 8'h00) begin
						if (str_len > max_len) begin
							broken = 1'b1;
							phase = P_SKIP;
						end else begin
							str_len = '0;
							phase = (phase == P_NAME) ? P_ADDR : P_POP;
						end
					end else if (str_len != 16'hFFFF) begin
						str_len = str_len + 1'b1;
					end
					field_idx = '0;
				end
				P_POP: begin
					field_idx = field_idx + 1'b1;
					if (field_idx == 3'd4) begin
						field_idx = '0;
						phase = P_REALM_A;
					end
				end
				P_REALM_A: phase = P_REALM_B;
				P_REALM_B: phase = P_REALM_C;
				P_REALM_C: begin
					if (has_version) begin
						field_idx = '0;
						phase = P_VERSION;
					end else begin
						close_realm();
					end
				end
				P_VERSION: begin
					field_idx = field_idx + 1'b1;
					if (field_idx == 3'd5)
						close_realm();
				end
				P_TRAIL: begin
					field_idx = field_idx + 1'b1;
					if (field_idx == 3'd2) begin
						field_idx = '0;
						phase = P_DONE;
					end
				end
				P_DONE: begin
					broken = 1'b1;
					phase = P_SKIP;
				end
				default: ;
			endcase
			if (body_left == 0)
				close_frame();
			else if (lst)
				post_verdict(rlpv_pkg::ST_NEED_MORE, '0,
					{1'b0, declared_size} + 17'd2 - {1'b0, body_left});
		end
	endtask

	task automatic push_byte(input logic [rlpv_pkg::DATA_W-1:0] d, input logic l);
		pending_bytes.push_back('{data: d, last: l});
	endtask

	// Builds one frame of the given kind. A name_len of zero or more forces the first name.
	task automatic add_frame(input frame_kind_t kind, input int name_len);
		logic [rlpv_pkg::DATA_W-1:0] body[$];
		logic [rlpv_pkg::DATA_W-1:0] flags;
		logic [rlpv_pkg::COUNT_W-1:0] count;
		logic [rlpv_pkg::LEN_W-1:0] frame_size;
		int n_realms;
		int long_slot;
		int len;
		int cut;
		int cap;
		logic end_flag;
		if (kind == FR_NOISE) begin
			repeat ($urandom_range(1, 12))
				push_byte(8'($urandom), $urandom_range(0, 5) == 0);
			// A final byte marked as the end of the buffer puts the parser back at a size prefix.
			push_byte(8'($urandom), 1'b1);
			return;
		end
		n_realms = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
		long_slot = -1;
		if (kind == FR_LONG_STR && max_len <= 300) begin
			if (n_realms == 0)
				n_realms = 1;
			long_slot = $urandom_range(0, 2 * n_realms - 1);
		end
		if (name_len >= 0 && n_realms == 0)
			n_realms = 1;
		cap = (max_len < 12) ? int'(max_len) : 12;
		repeat (4) body.push_back(8'($urandom));
		count = (kind == FR_BADCOUNT) ? 16'($urandom) : 16'(n_realms);
		body.push_back(count[7:0]);
		body.push_back(count[15:8]);
		for (int r = 0; r < n_realms; r++) begin
			flags = 8'($urandom);
			body.push_back(8'($urandom));
			body.push_back(8'($urandom));
			body.push_back(flags);
			for (int s = 0; s < 2; s++) begin
				if (2 * r + s == long_slot)
					len = int'(max_len) + 1;
				else if (r == 0 && s == 0 && name_len >= 0)
					len = name_len;
				else if ($urandom_range(0, 3) == 0)
					len = cap;
				else
					len = $urandom_range(0, cap);
				repeat (len) body.push_back(8'($urandom_range(1, 255)));
				body.push_back(8'h00);
			end
			repeat (7) body.push_back(8'($urandom));
			if ((flags & rlpv_pkg::VERSION_FLAG) != 0)
				repeat (5) body.push_back(8'($urandom));
		end
		repeat (2) body.push_back(8'($urandom));
		if (kind == FR_EXTRA) begin
			repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
		end else if (kind == FR_SHORT) begin
			len = $urandom_range(0, body.size() - 1);
			while (body.size() > len)
				void'(body.pop_back());
		end
		frame_size = 16'(body.size());
		body.push_front(frame_size[15:8]);
		body.push_front(frame_size[7:0]);
		cut = (kind == FR_CUT) ? $urandom_range(0, body.size() - 2) : body.size() - 1;
		end_flag = (kind == FR_CUT) ? 1'b1 : ($urandom_range(0, 2) == 0);
		for (int i = 0; i <= cut; i++)
			push_byte(body[i], (i == cut) ? end_flag : 1'b0);
	endtask

	task automatic add_random_frames(input int budget);
		int target;
		int pick;
		frame_kind_t kind;
		target = pending_bytes.size() + budget;
		while (pending_bytes.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				kind = FR_GOOD;
			else if (pick < 73)
				kind = FR_EXTRA;
			else if (pick < 81)
				kind = FR_SHORT;
			else if (pick < 89)
				kind = FR_CUT;
			else if (pick < 94)
				kind = FR_LONG_STR;
			else if (pick < 97)
				kind = FR_BADCOUNT;
			else
				kind = FR_NOISE;
			add_frame(kind, -1);
		end
	endtask

	// Holds the caller until the stream is sent and every verdict has come back.
	task automatic drain_results();
		do
			@(posedge clk);
		while (pending_bytes.size() != 0 || in_ch.valid || expected_verdicts.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_max_len(input logic [rlpv_pkg::LEN_W-1:0] value);
		@(posedge clk);
		cfg_ch.data <= value;
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		max_len = value;
		cfg_writes++;
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				parse_byte(in_ch.data_byte, in_ch.last_byte);
				bytes_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					cur_byte = pending_bytes.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.data_byte <= cur_byte.data;
					in_ch.last_byte <= cur_byte.last;
					if (burst_left == 0)
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 20);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each transfer and stalls on a rotating pattern that is reloaded now and then.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected result: status %0d, realm_total %0d, frame_bytes %0d",
						out_ch.status, out_ch.realm_total, out_ch.frame_bytes);
					errors++;
				end else begin
					seen = expected_verdicts.pop_front();
					if (out_ch.status !== seen.status) begin
						$error("status: expected %0d, got %0d", seen.status, out_ch.status);
						errors++;
					end
					if (out_ch.realm_total !== seen.realm_total) begin
						$error("realm_total: expected %0d, got %0d", seen.realm_total,
							out_ch.realm_total);
						errors++;
					end
					if (out_ch.frame_bytes !== seen.frame_bytes) begin
						$error("frame_bytes: expected %0d, got %0d", seen.frame_bytes,
							out_ch.frame_bytes);
						errors++;
					end
					case (seen.status)
						rlpv_pkg::ST_ACCEPTED: n_accepted++;
						rlpv_pkg::ST_CORRUPT:  n_corrupt++;
						default:               n_need_more++;
					endcase
				end
			end
			if (pattern_age == 0) begin
				stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
				pattern_age <= $urandom_range(16, 96);
			end else begin
				stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
				pattern_age <= pattern_age - 1;
			end
			out_ch.ready <= stall_pattern[0];
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [rlpv_pkg::LEN_W-1:0] limits[6];
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Zero declared size is answered right after the size high byte.
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		// Smallest valid frame, its final byte also flagged as the end of the buffer.
		push_byte(8'h08, 1'b0);
		push_byte(8'h00, 1'b0);
		repeat (4) push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b1);
		// Buffer ends after one, two and three bytes of a frame.
		push_byte(8'hFF, 1'b1);
		push_byte(8'h10, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		// Largest realm count in a body far too short to hold it.
		push_byte(8'h08, 1'b0);
		push_byte(8'h00, 1'b0);
		repeat (4) push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		drain_results();

		limits = '{16'd0, 16'd3, 16'hFFFF, 16'd1, rlpv_pkg::DEFAULT_MAX_STRING,
			16'($urandom_range(4, 20))};
		foreach (limits[i]) begin
			set_max_len(limits[i]);
			if (limits[i] == rlpv_pkg::DEFAULT_MAX_STRING) begin
				// Names exactly at the limit and one past it.
				add_frame(FR_GOOD, 256);
				add_frame(FR_GOOD, 257);
			end
			add_random_frames(PHASE_BYTES / 2);
			drain_results();
			add_random_frames(PHASE_BYTES / 2);
			drain_results();
		end

		$display("Sent %0d stream bytes under %0d string limits; verdicts: %0d accepted,",
			bytes_taken, cfg_writes, n_accepted);
		$display("%0d corrupt, %0d incomplete.", n_corrupt, n_need_more);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/rlpv_pkg.sv
sv/rlpv_intf.sv
sv/rlpv_parser.sv
sv/realm_list_packet_validator_top.sv
test/realm_list_packet_validator_top_tb.sv
